// File: design/trfs_pkg.sv
// Shared types and constants for the TFT rectangle-fill sequencer.
// Holds the request and response payload structs and the panel command codes.
// Has no dependencies.
`default_nettype none
package trfs_pkg;

   localparam int unsigned COORD_W  = 9;
   localparam int unsigned OFFSET_W = 8;
   localparam int unsigned BOUND_W  = 10;
   localparam int unsigned COLOR_W  = 16;
   localparam int unsigned COUNT_W  = 18;
   localparam int unsigned PHASE_W  = 4;

   localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
   localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
   localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

   localparam logic MODE_FILL = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   localparam logic REG_COLUMN_OFFSET = 1'b0;
   localparam logic REG_ROW_OFFSET    = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [COORD_W-1:0] x_start;
      logic [COORD_W-1:0] y_start;
      logic [COORD_W-1:0] rect_width;
      logic [COORD_W-1:0] rect_height;
      logic [COLOR_W-1:0] fill_color;
   } req_type;

   typedef struct packed {
      logic [7:0] link_byte;
      logic       is_data;
      logic       frame_end;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic               ok;
      logic [BOUND_W-1:0] col_start;
      logic [BOUND_W-1:0] col_end;
      logic [BOUND_W-1:0] row_start;
      logic [BOUND_W-1:0] row_end;
      logic [COUNT_W-1:0] pixel_count;
   } win_type;

endpackage
`default_nettype wire

// File: design/trfs_window.sv
// Window setup logic: validates a fill request, clips it to the panel and
// adds the offsets to form the window bounds and the pixel count.
// Depends on trfs_pkg.
`default_nettype none
module trfs_window #(
   parameter int unsigned PANEL_WIDTH  = 128,
   parameter int unsigned PANEL_HEIGHT = 160
) (
   input  var trfs_pkg::req_type                    req,
   input  var logic [trfs_pkg::OFFSET_W-1:0]        column_offset,
   input  var logic [trfs_pkg::OFFSET_W-1:0]        row_offset,
   output var trfs_pkg::win_type                    win
);
   import trfs_pkg::*;

   localparam logic [COORD_W:0] PanelW = (COORD_W+1)'(PANEL_WIDTH);
   localparam logic [COORD_W:0] PanelH = (COORD_W+1)'(PANEL_HEIGHT);

   logic [COORD_W:0]   x_ext;
   logic [COORD_W:0]   y_ext;
   logic [COORD_W:0]   x_sum;
   logic [COORD_W:0]   y_sum;
   logic [COORD_W-1:0] w_clip;
   logic [COORD_W-1:0] h_clip;

   always_comb begin
      x_ext = {1'b0, req.x_start};
      y_ext = {1'b0, req.y_start};
      x_sum = x_ext + {1'b0, req.rect_width};
      y_sum = y_ext + {1'b0, req.rect_height};
      w_clip = (x_sum > PanelW) ? COORD_W'(PanelW - x_ext) : req.rect_width;
      h_clip = (y_sum > PanelH) ? COORD_W'(PanelH - y_ext) : req.rect_height;

      win.ok = (req.rect_width != '0) && (req.rect_height != '0)
               && (x_ext < PanelW) && (y_ext < PanelH);
      win.col_start = BOUND_W'(req.x_start) + BOUND_W'(column_offset);
      win.col_end   = win.col_start + BOUND_W'(w_clip) - BOUND_W'(1);
      win.row_start = BOUND_W'(req.y_start) + BOUND_W'(row_offset);
      win.row_end   = win.row_start + BOUND_W'(h_clip) - BOUND_W'(1);
      win.pixel_count = COUNT_W'(w_clip) * COUNT_W'(h_clip);
   end

endmodule
`default_nettype wire

// File: design/trfs_sequencer.sv
// Byte sequencer: holds the window, color and progress of the current fill
// and produces one link byte for every tick while a fill is in progress.
// Depends on trfs_pkg.
`default_nettype none
module trfs_sequencer (
   input  var logic                 clock,
   input  var logic                 reset,
   input  var logic                 req_fire,
   input  var trfs_pkg::req_type    req,
   input  var trfs_pkg::win_type    win,
   output var logic                 rsp_produce,
   output var trfs_pkg::rsp_type    rsp
);
   import trfs_pkg::*;

   localparam logic [PHASE_W-1:0] PH_COL_CMD = 4'd0;
   localparam logic [PHASE_W-1:0] PH_COL_SH  = 4'd1;
   localparam logic [PHASE_W-1:0] PH_COL_SL  = 4'd2;
   localparam logic [PHASE_W-1:0] PH_COL_EH  = 4'd3;
   localparam logic [PHASE_W-1:0] PH_COL_EL  = 4'd4;
   localparam logic [PHASE_W-1:0] PH_ROW_CMD = 4'd5;
   localparam logic [PHASE_W-1:0] PH_ROW_SH  = 4'd6;
   localparam logic [PHASE_W-1:0] PH_ROW_SL  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_ROW_EH  = 4'd8;
   localparam logic [PHASE_W-1:0] PH_ROW_EL  = 4'd9;
   localparam logic [PHASE_W-1:0] PH_MEM_CMD = 4'd10;
   localparam logic [PHASE_W-1:0] PH_PIXELS  = 4'd11;

   logic                 active_ff, active_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [COUNT_W-1:0]   pixels_left_ff, pixels_left_in;
   logic                 low_half_ff, low_half_in;
   logic [BOUND_W-1:0]   col_start_ff, col_end_ff, row_start_ff, row_end_ff;
   logic [COLOR_W-1:0]   color_ff;
   logic                 load;
   logic                 tick;
   logic [COUNT_W-1:0]   pixels_dec;
   logic                 done;

   function automatic logic [7:0] hi_byte(input logic [BOUND_W-1:0] v);
      hi_byte = 8'(v >> 8);
   endfunction

   always_comb begin
      load = req_fire && (req.mode == MODE_FILL) && !active_ff && win.ok;
      tick = req_fire && (req.mode == MODE_TICK) && active_ff;
      pixels_dec = pixels_left_ff - COUNT_W'(1);
      done = (pixels_dec == '0);

      active_in      = active_ff;
      phase_in       = phase_ff;
      pixels_left_in = pixels_left_ff;
      low_half_in    = low_half_ff;
      rsp_produce    = tick;
      rsp.link_byte  = '0;
      rsp.is_data    = 1'b1;
      rsp.frame_end  = 1'b0;
      rsp.last       = 1'b0;

      case (phase_ff)
         PH_COL_CMD: begin
            rsp.link_byte = CMD_COLUMN_SET;
            rsp.is_data   = 1'b0;
         end
         PH_COL_SH: rsp.link_byte = hi_byte(col_start_ff);
         PH_COL_SL: rsp.link_byte = col_start_ff[7:0];
         PH_COL_EH: rsp.link_byte = hi_byte(col_end_ff);
         PH_COL_EL: begin
            rsp.link_byte = col_end_ff[7:0];
            rsp.frame_end = 1'b1;
         end
         PH_ROW_CMD: begin
            rsp.link_byte = CMD_ROW_SET;
            rsp.is_data   = 1'b0;
         end
         PH_ROW_SH: rsp.link_byte = hi_byte(row_start_ff);
         PH_ROW_SL: rsp.link_byte = row_start_ff[7:0];
         PH_ROW_EH: rsp.link_byte = hi_byte(row_end_ff);
         PH_ROW_EL: begin
            rsp.link_byte = row_end_ff[7:0];
            rsp.frame_end = 1'b1;
         end
         PH_MEM_CMD: begin
            rsp.link_byte = CMD_MEMORY_WRITE;
            rsp.is_data   = 1'b0;
            rsp.frame_end = 1'b1;
         end
         default: begin
            if (!low_half_ff) begin
               rsp.link_byte = color_ff[15:8];
            end else begin
               rsp.link_byte = color_ff[7:0];
               rsp.frame_end = done;
               rsp.last      = done;
            end
         end
      endcase

      if (tick) begin
         if (phase_ff < PH_PIXELS) begin
            phase_in = phase_ff + PHASE_W'(1);
         end else if (!low_half_ff) begin
            low_half_in = 1'b1;
         end else begin
            low_half_in    = 1'b0;
            pixels_left_in = pixels_dec;
            if (done) begin
               active_in = 1'b0;
               phase_in  = PH_COL_CMD;
            end
         end
      end

      if (load) begin
         active_in      = 1'b1;
         phase_in       = PH_COL_CMD;
         pixels_left_in = win.pixel_count;
         low_half_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         phase_ff       <= PH_COL_CMD;
         pixels_left_ff <= '0;
         low_half_ff    <= 1'b0;
      end else begin
         active_ff      <= active_in;
         phase_ff       <= phase_in;
         pixels_left_ff <= pixels_left_in;
         low_half_ff    <= low_half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         col_start_ff <= win.col_start;
         col_end_ff   <= win.col_end;
         row_start_ff <= win.row_start;
         row_end_ff   <= win.row_end;
         color_ff     <= req.fill_color;
      end
   end

endmodule
`default_nettype wire

// File: design/tft_rect_fill_sequencer.sv
// Top level of the TFT rectangle-fill sequencer: offset registers,
// request/response handshake and the response register.
// Depends on trfs_pkg, trfs_window and trfs_sequencer.
//
// Usage:
//   A request with mode 0 starts a fill: it carries the rectangle and the
//   color. It is dropped if the block is busy, if width or height is zero,
//   or if the start lies outside the panel. A request with mode 1 is one
//   byte-slot tick; while a fill is in progress each tick yields exactly one
//   response (link byte, data/command flag, frame end, last). Ticks while
//   idle yield nothing.
//   The response for a tick is valid in the cycle after the tick is
//   accepted. One request can be accepted per cycle while the receiver
//   takes responses. A stalled receiver holds the response register;
//   req_ready then drops until the response is taken. Offsets are
//   written on csr_we, index 0 for the column offset and 1 for the row
//   offset; the user writes them only while the block is idle, which the
//   block itself does not enforce. Reset clears the offsets, ends any
//   fill and empties the response register.
`default_nettype none
module tft_rect_fill_sequencer #(
   parameter int unsigned PANEL_WIDTH  = 128,
   parameter int unsigned PANEL_HEIGHT = 160
) (
   input  var logic                           clock,
   input  var logic                           reset,
   input  var logic                           req_valid,
   output var logic                           req_ready,
   input  var trfs_pkg::req_type              req_data,
   output var logic                           rsp_valid,
   input  var logic                           rsp_ready,
   output var trfs_pkg::rsp_type              rsp_data,
   input  var logic                           csr_we,
   input  var logic                           csr_index,
   input  var logic [trfs_pkg::OFFSET_W-1:0]  csr_wdata
);
   import trfs_pkg::*;

   logic [OFFSET_W-1:0] column_offset_ff, column_offset_in;
   logic [OFFSET_W-1:0] row_offset_ff, row_offset_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;
   logic                req_fire;
   logic                rsp_produce;
   rsp_type             rsp_next;
   win_type             win;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   trfs_window #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_window (
      .req           (req_data),
      .column_offset (column_offset_ff),
      .row_offset    (row_offset_ff),
      .win           (win)
   );

   trfs_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req         (req_data),
      .win         (win),
      .rsp_produce (rsp_produce),
      .rsp         (rsp_next)
   );

   always_comb begin
      column_offset_in = column_offset_ff;
      row_offset_in    = row_offset_ff;
      if (csr_we) begin
         case (csr_index)
            REG_COLUMN_OFFSET: column_offset_in = csr_wdata;
            REG_ROW_OFFSET:    row_offset_in    = csr_wdata;
            default:           column_offset_in = column_offset_ff;
         endcase
      end

      if (req_fire) begin
         rsp_valid_in = rsp_produce;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_offset_ff <= '0;
         row_offset_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         column_offset_ff <= column_offset_in;
         row_offset_ff    <= row_offset_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && rsp_produce) begin
         rsp_data_ff <= rsp_next;
      end
   end

endmodule
`default_nettype wire

// File: tb/sv/tb_tft_rect_fill_sequencer_checker.sv
`timescale 1ns / 100ps
// Checker for the TFT rectangle-fill sequencer: watches the request, response and
// offset-write ports, predicts every link byte and compares it field by field.
// Depends on trfs_pkg for the payload types and the panel command codes.
module tb_tft_rect_fill_sequencer_checker #(
   parameter int unsigned PANEL_W = 128,
   parameter int unsigned PANEL_H = 160
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  trfs_pkg::req_type             req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  trfs_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [trfs_pkg::OFFSET_W-1:0] csr_wdata,
   output int                            mismatch_count,
   output int                            pending_count,
   output int                            checked_count
);
   import trfs_pkg::*;

   localparam logic [3:0] PH_COLUMN_CMD  = 4'd0;
   localparam logic [3:0] PH_COLUMN_LAST = 4'd4;
   localparam logic [3:0] PH_ROW_CMD     = 4'd5;
   localparam logic [3:0] PH_ROW_LAST    = 4'd9;
   localparam logic [3:0] PH_MEMORY_CMD  = 4'd10;
   localparam logic [3:0] PH_PIXELS      = 4'd11;

   logic [7:0]   col_offset;
   logic [7:0]   row_offset;
   logic         filling;
   logic [3:0]   seq_phase;
   logic [15:0]  window_edge [4];
   logic [15:0]  color_held;
   logic [17:0]  pixels_remaining;
   logic         low_byte_next;
   rsp_type      link_bytes_due [$];

   function automatic void expect_link_byte(input logic [7:0] value, input logic data,
                                            input logic frame_end, input logic last);
      rsp_type r;
      r.link_byte = value;
      r.is_data   = data;
      r.frame_end = frame_end;
      r.last      = last;
      link_bytes_due.push_back(r);
   endfunction

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic step_fill_sequencer(input req_type r);
      int unsigned w;
      int unsigned h;
      logic [3:0]  k;
      logic [15:0] v;
      if (r.mode == MODE_FILL) begin
         if (!filling && r.rect_width != 0 && r.rect_height != 0 &&
             r.x_start < PANEL_W && r.y_start < PANEL_H) begin
            w = r.rect_width;
            h = r.rect_height;
            if (r.x_start + w > PANEL_W) w = PANEL_W - r.x_start;
            if (r.y_start + h > PANEL_H) h = PANEL_H - r.y_start;
            window_edge[0]   = 16'(r.x_start + col_offset);
            window_edge[1]   = 16'(window_edge[0] + w - 1);
            window_edge[2]   = 16'(r.y_start + row_offset);
            window_edge[3]   = 16'(window_edge[2] + h - 1);
            color_held       = r.fill_color;
            pixels_remaining = 18'(w * h);
            low_byte_next    = 1'b0;
            seq_phase        = PH_COLUMN_CMD;
            filling          = 1'b1;
         end
      end else if (filling) begin
         if (seq_phase == PH_PIXELS) begin
            if (!low_byte_next) begin
               expect_link_byte(color_held[15:8], 1'b1, 1'b0, 1'b0);
               low_byte_next = 1'b1;
            end else begin
               low_byte_next = 1'b0;
               pixels_remaining = pixels_remaining - 18'd1;
               expect_link_byte(color_held[7:0], 1'b1, pixels_remaining == 0,
                                pixels_remaining == 0);
               if (pixels_remaining == 0) begin
                  filling   = 1'b0;
                  seq_phase = PH_COLUMN_CMD;
               end
            end
         end else begin
            if (seq_phase == PH_COLUMN_CMD) begin
               expect_link_byte(CMD_COLUMN_SET, 1'b0, 1'b0, 1'b0);
            end else if (seq_phase <= PH_COLUMN_LAST) begin
               k = seq_phase - (PH_COLUMN_CMD + 4'd1);
               v = window_edge[{1'b0, k[1]}];
               expect_link_byte(k[0] ? v[7:0] : v[15:8], 1'b1,
                                seq_phase == PH_COLUMN_LAST, 1'b0);
            end else if (seq_phase == PH_ROW_CMD) begin
               expect_link_byte(CMD_ROW_SET, 1'b0, 1'b0, 1'b0);
            end else if (seq_phase <= PH_ROW_LAST) begin
               k = seq_phase - (PH_ROW_CMD + 4'd1);
               v = window_edge[{1'b1, k[1]}];
               expect_link_byte(k[0] ? v[7:0] : v[15:8], 1'b1,
                                seq_phase == PH_ROW_LAST, 1'b0);
            end else begin
               expect_link_byte(CMD_MEMORY_WRITE, 1'b0, 1'b1, 1'b0);
            end
            seq_phase = seq_phase + 4'd1;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         col_offset       = '0;
         row_offset       = '0;
         filling          = 1'b0;
         seq_phase        = PH_COLUMN_CMD;
         pixels_remaining = '0;
         low_byte_next    = 1'b0;
         link_bytes_due.delete();
         mismatch_count   = 0;
         checked_count    = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (link_bytes_due.size() == 0) begin
               $display("%0t: response with nothing expected, expected none, actual %h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = link_bytes_due.pop_front();
               check_field("link_byte", want.link_byte, rsp_data.link_byte);
               check_field("is_data", want.is_data, rsp_data.is_data);
               check_field("frame_end", want.frame_end, rsp_data.frame_end);
               check_field("last", want.last, rsp_data.last);
               checked_count++;
            end
         end
         if (csr_we) begin
            if (csr_index == REG_COLUMN_OFFSET) col_offset = csr_wdata;
            else if (csr_index == REG_ROW_OFFSET) row_offset = csr_wdata;
         end
         if (req_valid && req_ready) step_fill_sequencer(req_data);
      end
      pending_count <= link_bytes_due.size();
   end

endmodule

// File: tb/sv/tb_tft_rect_fill_sequencer.sv
`timescale 1ns / 100ps
// Top of the TFT rectangle-fill sequencer testbench: clock, reset, request and
// offset stimulus, receiver stalls and the verdict.
// Depends on trfs_pkg, the sequencer RTL and tb_tft_rect_fill_sequencer_checker.
module tb_tft_rect_fill_sequencer;
   import trfs_pkg::*;

   localparam int unsigned PANEL_W     = 128;
   localparam int unsigned PANEL_H     = 160;
   localparam int          HOLD_CYCLES = 200;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          PHASE_ITEMS = 180;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_we    = 1'b0;
   logic                csr_index = REG_COLUMN_OFFSET;
   logic [OFFSET_W-1:0] csr_wdata = '0;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int holds_asked   = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int cycle_count   = 0;
   int stim_count    = 0;
   int fills_run     = 0;

   tft_rect_fill_sequencer #(
      .PANEL_WIDTH  (PANEL_W),
      .PANEL_HEIGHT (PANEL_H)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tb_tft_rect_fill_sequencer_checker #(
      .PANEL_W (PANEL_W),
      .PANEL_H (PANEL_H)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, pending_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_ready    <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic req_type random_payload(input logic mode);
      req_type r;
      r.mode        = mode;
      r.x_start     = COORD_W'($urandom_range(511));
      r.y_start     = COORD_W'($urandom_range(511));
      r.rect_width  = COORD_W'($urandom_range(511));
      r.rect_height = COORD_W'($urandom_range(511));
      r.fill_color  = COLOR_W'($urandom_range(65535));
      return r;
   endfunction

   function automatic req_type make_fill(input int x, input int y, input int w,
                                         input int h, input logic [15:0] color);
      req_type r;
      r.mode        = MODE_FILL;
      r.x_start     = COORD_W'(x);
      r.y_start     = COORD_W'(y);
      r.rect_width  = COORD_W'(w);
      r.rect_height = COORD_W'(h);
      r.fill_color  = color;
      return r;
   endfunction

   // Ticks needed to drain a fill: eleven window bytes plus two per clipped pixel.
   function automatic int fill_ticks(input req_type f);
      int unsigned w;
      int unsigned h;
      if (f.rect_width == 0 || f.rect_height == 0 ||
          f.x_start >= PANEL_W || f.y_start >= PANEL_H) return 0;
      w = (f.x_start + f.rect_width > PANEL_W) ? PANEL_W - f.x_start : f.rect_width;
      h = (f.y_start + f.rect_height > PANEL_H) ? PANEL_H - f.y_start : f.rect_height;
      return 11 + 2 * w * h;
   endfunction

   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic run_fill(input req_type f);
      int n;
      n = fill_ticks(f);
      send_request(f);
      if (n > 0) fills_run++;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 4) send_request(random_payload(MODE_FILL));
         send_request(random_payload(MODE_TICK));
      end
      stim_count += n + 1;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_offsets(input logic [7:0] col, input logic [7:0] row);
      csr_we    <= 1'b1;
      csr_index <= REG_COLUMN_OFFSET;
      csr_wdata <= col;
      @(posedge clock);
      csr_index <= REG_ROW_OFFSET;
      csr_wdata <= row;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int      idle_by_phase  [4];
      int      stall_by_phase [4];
      int      target;
      req_type f;
      idle_by_phase  = '{0, 52, 0, 19};
      stall_by_phase = '{0, 0, 52, 19};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < 4; p++) begin
         wait_drained();
         case (p)
            0: write_offsets(8'hFF, 8'hFF);
            1: write_offsets(8'h00, 8'h00);
            default: write_offsets(8'($urandom_range(255)), 8'($urandom_range(255)));
         endcase
         send_idle_pct = idle_by_phase[p];
         stall_pct     = stall_by_phase[p];
         if (p == 0) begin
            run_fill(make_fill(0, 0, 1, 1, 16'h0000));
            run_fill(make_fill(127, 159, 1, 1, 16'hFFFF));
            run_fill(make_fill(0, 0, 511, 1, 16'hA55A));
            run_fill(make_fill(0, 0, 1, 511, 16'h5AA5));
            run_fill(make_fill(126, 158, 511, 511, 16'h1234));
            send_request(make_fill(10, 20, 2, 1, 16'h8001));
            send_request(make_fill(0, 0, 5, 5, 16'h7FFE));
            for (int i = 0; i < 15; i++) send_request(random_payload(MODE_TICK));
            run_fill(make_fill(5, 5, 0, 7, 16'h00FF));
            run_fill(make_fill(5, 5, 7, 0, 16'hFF00));
            run_fill(make_fill(PANEL_W, 0, 1, 1, 16'h0F0F));
            run_fill(make_fill(0, PANEL_H, 1, 1, 16'hF0F0));
            run_fill(make_fill(511, 511, 511, 511, 16'hFFFF));
            send_request(random_payload(MODE_TICK));
            wait_drained();
            // The receiver holds off while ticks keep coming, so the input backs up.
            holds_asked++;
            run_fill(make_fill(40, 50, 3, 4, 16'hC3C3));
            wait_drained();
         end
         target = stim_count + PHASE_ITEMS;
         while (stim_count < target) begin
            if ($urandom_range(9) < 2) begin
               if ($urandom_range(1) == 0) begin
                  send_request(random_payload(MODE_TICK));
               end else begin
                  f = random_payload(MODE_FILL);
                  case ($urandom_range(3))
                     0: f.rect_width = '0;
                     1: f.rect_height = '0;
                     2: f.x_start = COORD_W'($urandom_range(511, PANEL_W));
                     default: f.y_start = COORD_W'($urandom_range(511, PANEL_H));
                  endcase
                  send_request(f);
               end
            end else begin
               f = make_fill($urandom_range(PANEL_W - 1), $urandom_range(PANEL_H - 1),
                             $urandom_range(1, 4), $urandom_range(1, 4),
                             16'($urandom_range(65535)));
               if ($urandom_range(3) == 0) begin
                  f.x_start    = COORD_W'(PANEL_W - $urandom_range(1, 3));
                  f.rect_width = COORD_W'($urandom_range(1, 511));
               end
               if ($urandom_range(3) == 0) begin
                  f.y_start     = COORD_W'(PANEL_H - $urandom_range(1, 3));
                  f.rect_height = COORD_W'($urandom_range(1, 511));
               end
               run_fill(f);
            end
         end
      end
      wait_drained();
      repeat (8) @(posedge clock);
      $display("Ran %0d accepted fills and %0d requests in four offset and stall settings;",
               fills_run, stim_count);
      $display("%0d link bytes checked, with clipped, rejected, busy and idle-tick requests.",
               checked_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/trfs_pkg.sv
design/trfs_window.sv
design/trfs_sequencer.sv
design/tft_rect_fill_sequencer.sv
tb/sv/tb_tft_rect_fill_sequencer_checker.sv
tb/sv/tb_tft_rect_fill_sequencer.sv
